>>> rtl/core/dqnd_pkg.sv
`default_nettype none
package dqnd_pkg;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic [15:0] packet_length;
    logic        last_byte;
  } dqnd_in_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       done_res;
    logic       failed;
  } dqnd_out_t;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  // width of position + 1 + label length, wide enough for any position width up to 16
  localparam int SUM_W = 17;

endpackage
`default_nettype wire

>>> rtl/core/dqnd_parse.sv
`default_nettype none
module dqnd_parse #(
  parameter int HEADER_BYTES  = 12,
  parameter int POSITION_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   fire,
  input  dqnd_pkg::dqnd_in_t    item,
  output logic                  res_valid,
  output dqnd_pkg::dqnd_out_t   res
);
  import dqnd_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_LABEL  = 2'd2;
  localparam logic [1:0] PH_ENDED  = 2'd3;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] HDR_POS = POSITION_BITS'(HEADER_BYTES);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               left_r, left_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic                     started_r, started_nxt;

  logic [1:0]       ph;
  logic [SUM_W-1:0] cur_x;
  logic [SUM_W-1:0] len_x;
  logic [SUM_W-1:0] end_x;
  logic [7:0]       left_dec;

  always_comb begin
    ph          = phase_r;
    cur_x       = SUM_W'(pos_r);
    len_x       = SUM_W'(item.packet_length);
    end_x       = cur_x + SUM_W'(1) + SUM_W'(item.packet_byte);
    left_dec    = left_r - 8'd1;
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    started_nxt = started_r;
    pos_nxt     = pos_r;
    res_valid   = 1'b0;
    res         = '0;

    if (phase_r == PH_HEADER && pos_r >= HDR_POS) begin
      ph = PH_LENGTH;
    end
    phase_nxt = ph;

    unique case (ph)
      PH_LENGTH: begin
        if (cur_x >= len_x) begin
          res_valid     = 1'b1;
          res.done_res  = 1'b1;
          res.failed    = 1'b1;
          phase_nxt     = PH_ENDED;
        end else if (item.packet_byte == 8'd0) begin
          res_valid     = 1'b1;
          res.done_res  = 1'b1;
          res.failed    = ~started_r;
          phase_nxt     = PH_ENDED;
        end else if (end_x >= len_x) begin
          // label would run into the last byte
          res_valid     = 1'b1;
          res.done_res  = 1'b1;
          res.failed    = 1'b1;
          phase_nxt     = PH_ENDED;
        end else begin
          if (started_r) begin
            res_valid     = 1'b1;
            res.name_char = DOT_CHAR;
          end
          started_nxt = 1'b1;
          left_nxt    = item.packet_byte;
          phase_nxt   = PH_LABEL;
        end
      end
      PH_LABEL: begin
        res_valid     = 1'b1;
        res.name_char = item.packet_byte;
        left_nxt      = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_LENGTH;
        end
      end
      default: begin
      end
    endcase

    if (item.last_byte) begin
      // packet over: unless the name has already closed, send a failed closing beat, then start over
      if (phase_nxt != PH_ENDED) begin
        res_valid = 1'b1;
        res       = '0;
        res.done_res = 1'b1;
        res.failed   = 1'b1;
      end
      phase_nxt   = PH_HEADER;
      left_nxt    = 8'd0;
      started_nxt = 1'b0;
      pos_nxt     = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      left_r    <= 8'd0;
      phase_r   <= PH_HEADER;
      started_r <= 1'b0;
    end else if (fire) begin
      pos_r     <= pos_nxt;
      left_r    <= left_nxt;
      phase_r   <= phase_nxt;
      started_r <= started_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dqnd_out_fifo.sv
`default_nettype none
module dqnd_out_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  dqnd_pkg::dqnd_out_t   push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire                   out_stall,
  output dqnd_pkg::dqnd_out_t   out_item
);
  import dqnd_pkg::*;

  dqnd_out_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dns_query_name_label_decoder_core.sv
// dns question-name decoder: turns a dns message, one byte per beat, into the
// question name as dotted text, one character per result beat.
// input channel: in_valid / in_stall with in_item (byte, packet length, last flag).
// result channel: out_valid / out_stall with out_item; a character beat has
// done_res low, the closing beat has done_res high, no character, and failed
// set when the name was empty, malformed or cut short by the end of packet.
// the header bytes are skipped; after the closing beat bytes produce nothing
// until the last byte of the packet, which returns the parser to its start.
// a result passes through the input register and then the result buffer
// before it can be taken.
// throughput: one byte per cycle while in_stall is low; the parse of each byte is a single compare
// and count between the input register and a two-entry result buffer.
// when the receiver stalls, the result buffer absorbs up to two beats, then
// in_stall rises until a beat is taken.
// reset (synchronous, rst_n low) empties both registers and returns the
// parser to the header.
`default_nettype none
module dns_query_name_label_decoder_core #(
  parameter int HEADER_BYTES  = 12,
  parameter int POSITION_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  dqnd_pkg::dqnd_in_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output dqnd_pkg::dqnd_out_t  out_item
);
  import dqnd_pkg::*;

  dqnd_in_t  stg_item_r;
  logic      stg_valid_r, stg_valid_nxt;
  logic      space;
  logic      fire;
  logic      res_valid;
  dqnd_out_t res;
  logic      in_take;

  assign fire     = stg_valid_r & space;
  assign in_stall = stg_valid_r & ~space;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_take) begin
      stg_valid_nxt = 1'b1;
    end else if (fire) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r <= in_item;
    end
  end

  dqnd_parse #(
    .HEADER_BYTES  (HEADER_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (stg_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  dqnd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire & res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/core/dqnd_checker.sv
`default_nettype none
module dqnd_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input dqnd_pkg::dqnd_out_t  out_item
);
  import dqnd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // closing beat carries no character
  a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_res |-> out_item.name_char == 8'd0)
    else $error("closing beat carries a character");

  // failure is only reported on the closing beat
  a_fail_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.done_res |-> !out_item.failed)
    else $error("failed set on a character beat");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind dns_query_name_label_decoder_core dqnd_checker u_dqnd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
